@@ design/sha1md_pkg.sv @@
`timescale 1ns / 1ps

package sha1md_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumH   = 5;
  localparam int unsigned BlkWds = 16;
  localparam int unsigned Rounds = 80;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [WordW-1:0] InitHash [NumH] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [WordW-1:0] RoundK0 = 32'h5A82_7999;
  localparam logic [WordW-1:0] RoundK1 = 32'h6ED9_EBA1;
  localparam logic [WordW-1:0] RoundK2 = 32'h8F1B_BCDC;
  localparam logic [WordW-1:0] RoundK3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [2:0] FullBytes = 3'd4;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        is_last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
  } out_t;

  // How the back end treats one queued word.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_LAST_FULL = 2'd1,
    KIND_LAST_PART = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    kind_e       kind;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic block_empty;
  } core_status_t;

endpackage

@@ design/sha1md_front.sv @@
`timescale 1ns / 1ps

module sha1md_front (
  input  sha1md_pkg::in_t    in_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sha1md_pkg::entry_t q_entry_o
);
  import sha1md_pkg::*;

  logic [2:0] nb;

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // Anything above four bytes counts as a full word.
  assign nb = in_i.valid_bytes[2] ? FullBytes : in_i.valid_bytes;

  always_comb begin
    q_entry_o.word   = in_i.data_word;
    q_entry_o.nbytes = FullBytes;
    q_entry_o.kind   = KIND_DATA;
    if (in_i.is_last) begin
      q_entry_o.nbytes = nb;
      if (nb[2]) begin
        q_entry_o.kind = KIND_LAST_FULL;
      end else begin
        // A partial last word already carries the padding marker.
        q_entry_o.kind = KIND_LAST_PART;
        unique case (nb[1:0])
          2'd0: q_entry_o.word = {PadByte, 24'h0};
          2'd1: q_entry_o.word = {in_i.data_word[31:24], PadByte, 16'h0};
          2'd2: q_entry_o.word = {in_i.data_word[31:16], PadByte, 8'h0};
          2'd3: q_entry_o.word = {in_i.data_word[31:8], PadByte};
          default: q_entry_o.word = {PadByte, 24'h0};
        endcase
      end
    end
  end

endmodule

@@ design/sha1md_queue.sv @@
`timescale 1ns / 1ps

module sha1md_queue #(
  parameter int unsigned Depth = sha1md_pkg::QueueDepthDefault,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned LvlW = $clog2(Depth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha1md_pkg::entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output sha1md_pkg::entry_t head_o,
  output logic [LvlW-1:0]    level_o
);
  import sha1md_pkg::*;

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [LvlW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == LvlW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign level_o = cnt_q;

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ design/sha1md_core.sv @@
`timescale 1ns / 1ps

module sha1md_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  sha1md_pkg::entry_t       head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output sha1md_pkg::out_t         out_o,
  output sha1md_pkg::core_status_t status_o
);
  import sha1md_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] w_q [BlkWds];
  logic [31:0] w_d [BlkWds];
  logic [31:0] h_q [NumH];
  logic [31:0] h_d [NumH];
  logic [31:0] v_q [NumH];
  logic [31:0] v_d [NumH];
  logic [3:0]  pos_q, pos_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [63:0] count_q, count_d;
  logic        need_marker_q, need_marker_d;
  logic        len_blk_q, len_blk_d;
  logic        finishing_q, finishing_d;
  logic        final_q, final_d;
  out_t        digest_q, digest_d;
  logic        out_valid_q, out_valid_d;

  logic        shift_en;
  logic [31:0] shift_word;
  logic [63:0] bit_len;
  logic [31:0] f_val, k_val, t_val, sched;

  assign bit_len = {count_q[60:0], 3'b000};
  assign sched   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

  // Round function and constant by round group.
  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
      k_val = RoundK0;
    end else if (rnd_q < 7'd40) begin
      f_val = v_q[1] ^ v_q[2] ^ v_q[3];
      k_val = RoundK1;
    end else if (rnd_q < 7'd60) begin
      f_val = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
      k_val = RoundK2;
    end else begin
      f_val = v_q[1] ^ v_q[2] ^ v_q[3];
      k_val = RoundK3;
    end
  end

  assign t_val = {v_q[0][26:0], v_q[0][31:27]} + f_val + v_q[4] + k_val + w_q[0];

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    rnd_d         = rnd_q;
    count_d       = count_q;
    need_marker_d = need_marker_q;
    len_blk_d     = len_blk_q;
    finishing_d   = finishing_q;
    final_d       = final_q;
    digest_d      = digest_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    h_d           = h_q;
    v_d           = v_q;
    pop_o         = 1'b0;
    shift_en      = 1'b0;
    shift_word    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.kind)
            KIND_DATA: begin
              shift_en   = 1'b1;
              shift_word = head_i.word;
              count_d    = count_q + 64'(FullBytes);
            end
            KIND_LAST_FULL: begin
              shift_en      = 1'b1;
              shift_word    = head_i.word;
              count_d       = count_q + 64'(FullBytes);
              need_marker_d = 1'b1;
              finishing_d   = 1'b1;
            end
            KIND_LAST_PART: begin
              shift_en    = 1'b1;
              shift_word  = head_i.word;
              count_d     = count_q + 64'(head_i.nbytes);
              len_blk_d   = (pos_q <= 4'd13);
              finishing_d = 1'b1;
            end
            default: begin
              shift_en = 1'b0;
            end
          endcase
          if (shift_en) begin
            if (pos_q == 4'd15) begin
              state_d = ST_ROUND;
              pos_d   = '0;
              rnd_d   = '0;
              v_d     = h_q;
            end else begin
              pos_d   = pos_q + 1'b1;
              state_d = finishing_d ? ST_PAD : ST_IDLE;
            end
          end
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
        if (need_marker_q) begin
          shift_word    = {PadByte, 24'h0};
          need_marker_d = 1'b0;
          len_blk_d     = (pos_q <= 4'd13);
        end else if (len_blk_q && pos_q == 4'd14) begin
          shift_word = bit_len[63:32];
        end else if (len_blk_q && pos_q == 4'd15) begin
          shift_word = bit_len[31:0];
        end
        if (pos_q == 4'd15) begin
          final_d = ~need_marker_q & len_blk_q;
          state_d = ST_ROUND;
          pos_d   = '0;
          rnd_d   = '0;
          v_d     = h_q;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_ROUND: begin
        shift_en   = 1'b1;
        shift_word = {sched[30:0], sched[31]};
        v_d[0]     = t_val;
        v_d[1]     = v_q[0];
        v_d[2]     = {v_q[1][1:0], v_q[1][31:2]};
        v_d[3]     = v_q[2];
        v_d[4]     = v_q[3];
        rnd_d      = rnd_q + 1'b1;
        if (rnd_q == 7'(Rounds - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int j = 0; j < NumH; j++) begin
          h_d[j] = h_q[j] + v_q[j];
        end
        if (final_q) begin
          state_d = ST_DONE;
        end else if (finishing_q) begin
          len_blk_d = 1'b1;
          state_d   = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          digest_d    = '{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
          out_valid_d = 1'b1;
          h_d         = InitHash;
          count_d     = '0;
          finishing_d = 1'b0;
          final_d     = 1'b0;
          len_blk_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    w_d = w_q;
    if (shift_en) begin
      for (int j = 0; j < BlkWds - 1; j++) begin
        w_d[j] = w_q[j+1];
      end
      w_d[BlkWds-1] = shift_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      rnd_q         <= '0;
      count_q       <= '0;
      need_marker_q <= 1'b0;
      len_blk_q     <= 1'b0;
      finishing_q   <= 1'b0;
      final_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      h_q           <= InitHash;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      rnd_q         <= rnd_d;
      count_q       <= count_d;
      need_marker_q <= need_marker_d;
      len_blk_q     <= len_blk_d;
      finishing_q   <= finishing_d;
      final_q       <= final_d;
      out_valid_q   <= out_valid_d;
      h_q           <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    v_q      <= v_d;
    digest_q <= digest_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_o                = digest_q;
  assign status_o.idle        = (state_q == ST_IDLE);
  assign status_o.block_empty = (pos_q == '0);

endmodule

@@ design/sha1_message_digest.sv @@
`timescale 1ns / 1ps

// SHA-1 engine for a message streamed as big-endian 32-bit words. Each input beat carries
// four message bytes; the beat flagged is_last carries zero to four bytes from its top end
// and closes the message, after which one output beat delivers the 160-bit digest and the
// engine starts over from the initial hash values. A front end classifies each beat and
// pre-pads a partial last word, and a small queue of QueueDepth entries lets it keep taking
// beats while the back end compresses. While idle, the back end takes one queued word per cycle
// into its 16-word schedule shift line; every sixteenth word starts the compression, which
// runs one round per cycle through a single round adder and then folds the result into the
// chaining value. Closing a message takes padding words, one or two compressions and a load
// of the digest register. The digest register is separate, so a digest may wait on the
// output while the next message is already being absorbed; the engine stalls only when it
// must place a second digest before the first has left.
// There is no clearing pass after reset.
module sha1_message_digest #(
  parameter int unsigned QueueDepth = sha1md_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha1md_pkg::in_t  in_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output sha1md_pkg::out_t out_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);
  import sha1md_pkg::*;

  localparam int unsigned LvlW = $clog2(QueueDepth + 1);

  logic            q_full, q_push, q_valid, q_pop;
  entry_t          q_entry, q_head;
  logic [LvlW-1:0] q_level;
  core_status_t    core_st;

  sha1md_front u_front (
    .in_i      (in_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  sha1md_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .head_o (q_head),
    .level_o(q_level)
  );

  sha1md_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .status_o    (core_st)
  );

  // An accepted input beat is held in the queue on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (q_level != '0))
    else $error("accepted beat missing from queue");

  // The back end only pops a word that is actually queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && q_level != '0))
    else $error("pop from empty queue");

  // A new digest appears only once the back end is idle with an empty block buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (core_st.idle && core_st.block_empty))
    else $error("digest emitted while message state not cleared");

endmodule
